### rtl/efr_pkg.sv
`default_nettype none
package efr_pkg;

   localparam int unsigned FRACTION_BITS_DEF = 16;

   localparam int unsigned FRAME_CFG_W = 16;
   localparam int unsigned DUR_W       = 24;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned DELAY_W     = 16;
   localparam int unsigned FRAME_W     = 24;
   localparam int unsigned ELAPSED_W   = 26;
   localparam int unsigned MOD_STEPS   = ELAPSED_W - 1;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_FRAME = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = 2'd3;

   localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOOP   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TURN   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ACCEL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DECEL  = 3'd4;

   typedef struct packed {
      logic capture;
      logic load_mod;
      logic load_div;
      logic step;
      logic shape;
      logic scale;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_mod;
      logic need_div;
   } sts_type;

endpackage
`default_nettype wire

### rtl/efr_if.sv
`default_nettype none
interface efr_req_if;
   import efr_pkg::*;
   logic               valid;
   logic               ready;
   logic               start_req;
   logic [DELAY_W-1:0] start_delay;
   logic               stop;
   modport source (output valid, start_req, start_delay, stop, input ready);
   modport sink   (input valid, start_req, start_delay, stop, output ready);
endinterface

interface efr_rsp_if;
   import efr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FRAME_W-1:0] frame_value;
   logic                      running;
   modport source (output valid, frame_value, running, input ready);
   modport sink   (input valid, frame_value, running, output ready);
endinterface
`default_nettype wire

### rtl/eased_frame_ramp_generator.sv
// Eased frame ramp generator.
// req_if carries one item per time tick: start_req (restart with start_delay
// ticks of wait), start_delay and stop. rsp_if returns exactly one item per
// tick: frame_value (signed, 8 fractional bits) and running.
// Both channels use valid/ready; an item moves when both are high.
// csr_wr_en/csr_index/csr_wdata write min_frame (0), max_frame (1),
// duration_ticks (2) and ramp_mode (3); write only while no tick is pending.
// One item is worked at a time. The steps for an item, by case:
//    loop and turn modes, active non-degenerate ramp, positive elapsed count:
//       a 25-step modulo pass, then a FRACTION_BITS+1 step divide, both on
//       one shift-subtract unit, then square and scale
//    other loop and turn ticks with a positive elapsed count and a nonzero
//       duration: the modulo pass but no divide, then square and scale
//    one-shot modes inside the ramp: the divide, then square and scale
//    all other ticks: square and scale only
// The next item is taken only once the block has finished the last one
// and is back in idle.
// The result sits in an output register; a new item is accepted while it
// waits, and a stalled receiver only holds the block at its final step.
// Synchronous reset clears the configuration, elapsed count, flag and held frame.
`default_nettype none
module eased_frame_ramp_generator #(
   parameter int unsigned FRACTION_BITS = efr_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   efr_req_if.sink                          req_if,
   efr_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [efr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import efr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   efr_ctrl #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   efr_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_start_req   (req_if.start_req),
      .req_start_delay (req_if.start_delay),
      .req_stop        (req_if.stop),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_frame_value (rsp_if.frame_value),
      .rsp_running     (rsp_if.running)
   );

endmodule
`default_nettype wire

### rtl/efr_ctrl.sv
`default_nettype none
module efr_ctrl #(
   parameter int unsigned FRACTION_BITS = efr_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  efr_pkg::sts_type sts,
   output efr_pkg::cmd_type cmd
);
   import efr_pkg::*;

   localparam int unsigned DIV_STEPS = FRACTION_BITS + 1;
   localparam int unsigned MAX_STEPS = (DIV_STEPS > MOD_STEPS) ? DIV_STEPS : MOD_STEPS;
   localparam int unsigned CNT_W     = $clog2(MAX_STEPS);
   localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EVAL  = 8'b0000_0010,
      ST_MOD   = 8'b0000_0100,
      ST_LDIV  = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_SHAPE = 8'b0010_0000,
      ST_SCALE = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cnt_in = '0;
            if (sts.need_mod) begin
               cmd.load_mod = 1'b1;
               state_in     = ST_MOD;
            end else if (sts.need_div) begin
               cmd.load_div = 1'b1;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_SHAPE;
            end
         end
         ST_MOD: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MOD_LAST) begin
               cnt_in   = '0;
               state_in = ST_LDIV;
            end
         end
         ST_LDIV: begin
            cmd.load_div = 1'b1;
            state_in     = sts.need_div ? ST_DIV : ST_SHAPE;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            cmd.shape = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### rtl/efr_datapath.sv
`default_nettype none
module efr_datapath #(
   parameter int unsigned FRACTION_BITS = efr_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [efr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [efr_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_start_req,
   input  logic [efr_pkg::DELAY_W-1:0]           req_start_delay,
   input  logic                                  req_stop,
   input  efr_pkg::cmd_type                      cmd,
   output efr_pkg::sts_type                      sts,
   output logic signed [efr_pkg::FRAME_W-1:0]    rsp_frame_value,
   output logic                                  rsp_running
);
   import efr_pkg::*;

   localparam int unsigned F   = FRACTION_BITS;
   localparam int unsigned SW  = F + 1;
   localparam int unsigned UW  = ELAPSED_W - 1;
   localparam int unsigned PW  = FRAME_CFG_W + SW;
   localparam logic [SW-1:0] ONE = {1'b1, {F{1'b0}}};
   localparam logic signed [ELAPSED_W-1:0] ELAPSED_MAX = {1'b0, {UW{1'b1}}};

   // configuration
   logic signed [FRAME_CFG_W-1:0] min_ff, max_ff;
   logic [DUR_W-1:0]              dur_ff;
   logic [MODE_W-1:0]             mode_ff;

   // ramp state
   logic signed [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                        active_ff, active_in;
   logic signed [FRAME_W-1:0]   held_ff;

   // captured item
   logic               start_ff, stop_ff;
   logic [DELAY_W-1:0] delay_ff;

   // shift-subtract unit
   logic [UW-1:0] rem_ff, dvd_ff, div_ff, c_ff;
   logic [SW-1:0] quo_ff;

   logic [2*SW-1:0] sqr_ff;
   logic [SW-1:0]   s_ff;
   logic [PW-1:0]   prod_ff;

   logic signed [FRAME_W-1:0] frame_ff;
   logic                      running_ff;

   logic signed [ELAPSED_W-1:0] e0, e1, dur_s;
   logic                        act0, e_pos, e_lt_dur, looped, degen, wrap;
   logic [UW-1:0]               per, num, dur_u;
   logic [ELAPSED_W-1:0]        t_sh, diff, cp1;
   logic                        ge;
   logic [SW-1:0]               s_sel, s_sq, sq_sh, s_fin;
   logic signed [FRAME_CFG_W:0] range_s;
   logic [FRAME_CFG_W-1:0]      mag;
   logic                        neg;
   logic [FRAME_W-1:0]          off, base;
   logic signed [FRAME_W-1:0]   frame_calc, frame_fin;

   always_comb begin
      e0       = start_ff ? $signed(ELAPSED_W'(0) - {{(ELAPSED_W-DELAY_W){1'b0}}, delay_ff})
                          : elapsed_ff;
      act0     = start_ff | active_ff;
      dur_s    = $signed({{(ELAPSED_W-DUR_W){1'b0}}, dur_ff});
      dur_u    = {{(UW-DUR_W){1'b0}}, dur_ff};
      e_pos    = (e0 > $signed(ELAPSED_W'(0)));
      e_lt_dur = (e0 < dur_s);
      looped   = (mode_ff == MODE_LOOP) || (mode_ff == MODE_TURN);
      degen    = (dur_ff == '0) || (min_ff == max_ff);
      wrap     = looped && (dur_ff != '0);
      per      = (mode_ff == MODE_LOOP) ? dur_u : {dur_ff, 1'b0};

      sts.need_mod = wrap && e_pos;
      if (degen) begin
         sts.need_div = 1'b0;
      end else if (looped) begin
         sts.need_div = act0 && e_pos;
      end else begin
         sts.need_div = act0 && e_pos && e_lt_dur;
      end

      // numerator of the phase fraction, never above the duration
      if (mode_ff == MODE_LOOP) begin
         num = rem_ff;
      end else if (mode_ff == MODE_TURN) begin
         num = (rem_ff <= dur_u) ? rem_ff : per - rem_ff;
      end else begin
         num = e0[UW-1:0];
      end

      t_sh = {rem_ff, dvd_ff[UW-1]};
      diff = t_sh - {1'b0, div_ff};
      ge   = (t_sh >= {1'b0, div_ff});

      if (!looped && (!act0 || !e_lt_dur)) begin
         s_sel = ONE;
      end else if (!looped && !e_pos) begin
         s_sel = '0;
      end else begin
         s_sel = quo_ff;
      end
      s_sq = (mode_ff == MODE_DECEL) ? ONE - s_sel : s_sel;

      sq_sh = sqr_ff[2*F:F];
      if (mode_ff == MODE_ACCEL) begin
         s_fin = sq_sh;
      end else if (mode_ff == MODE_DECEL) begin
         s_fin = ONE - sq_sh;
      end else begin
         s_fin = s_ff;
      end

      range_s = $signed({max_ff[FRAME_CFG_W-1], max_ff}) - $signed({min_ff[FRAME_CFG_W-1], min_ff});
      neg     = range_s[FRAME_CFG_W];
      mag     = neg ? FRAME_CFG_W'(-range_s) : range_s[FRAME_CFG_W-1:0];

      off        = prod_ff[F+15:F-8];
      base       = {min_ff, 8'h00};
      frame_calc = $signed(neg ? base - off : base + off);
      if (degen) begin
         frame_fin = $signed({max_ff, 8'h00});
      end else if (looped && !(act0 && e_pos)) begin
         frame_fin = held_ff;
      end else begin
         frame_fin = frame_calc;
      end

      active_in = act0;
      if (degen || (!looped && (!act0 || !e_lt_dur)) || stop_ff) begin
         active_in = 1'b0;
      end

      e1  = (e0 != ELAPSED_MAX) ? e0 + $signed(ELAPSED_W'(1)) : e0;
      cp1 = {1'b0, c_ff} + ELAPSED_W'(1);
      if (wrap && e_pos) begin
         if (e0 == ELAPSED_MAX) begin
            elapsed_in = $signed({1'b0, c_ff});
         end else if (cp1 == {1'b0, per}) begin
            elapsed_in = '0;
         end else begin
            elapsed_in = $signed(cp1);
         end
      end else if (wrap && (e1 == $signed(ELAPSED_W'(1))) && (per == UW'(1))) begin
         elapsed_in = '0;
      end else begin
         elapsed_in = e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= '0;
         max_ff     <= '0;
         dur_ff     <= '0;
         mode_ff    <= MODE_LINEAR;
         elapsed_ff <= '0;
         active_ff  <= 1'b0;
         held_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_FRAME: min_ff  <= $signed(csr_wdata[FRAME_CFG_W-1:0]);
               CSR_MAX_FRAME: max_ff  <= $signed(csr_wdata[FRAME_CFG_W-1:0]);
               CSR_DURATION:  dur_ff  <= csr_wdata[DUR_W-1:0];
               CSR_MODE:      mode_ff <= csr_wdata[MODE_W-1:0];
               default:       mode_ff <= mode_ff;
            endcase
         end
         if (cmd.finish) begin
            elapsed_ff <= elapsed_in;
            active_ff  <= active_in;
            held_ff    <= frame_fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= req_start_req;
         delay_ff <= req_start_delay;
         stop_ff  <= req_stop;
      end
      if (cmd.load_mod) begin
         rem_ff <= '0;
         dvd_ff <= e0[UW-1:0];
         div_ff <= per;
      end else if (cmd.load_div) begin
         c_ff   <= rem_ff;
         rem_ff <= num >> 1;
         dvd_ff <= {num[0], {(UW-1){1'b0}}};
         div_ff <= dur_u;
         quo_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= ge ? diff[UW-1:0] : t_sh[UW-1:0];
         dvd_ff <= {dvd_ff[UW-2:0], 1'b0};
         quo_ff <= {quo_ff[SW-2:0], ge};
      end
      if (cmd.shape) begin
         s_ff   <= s_sel;
         sqr_ff <= s_sq * s_sq;
      end
      if (cmd.scale) begin
         prod_ff <= mag * s_fin;
      end
      if (cmd.finish) begin
         frame_ff   <= frame_fin;
         running_ff <= active_in;
      end
   end

   assign rsp_frame_value = frame_ff;
   assign rsp_running     = running_ff;

endmodule
`default_nettype wire

### rtl/efr_checker.sv
`default_nettype none
module efr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [efr_pkg::FRAME_W-1:0]  rsp_frame_value,
   input logic                                rsp_running
);
   import efr_pkg::*;

   logic req_fire;
   assign req_fire = req_valid & req_ready;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_value) && $stable(rsp_running))
      else $error("stalled result changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("item taken while previous item in work");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_fire))
      else $error("result appeared one cycle after item");

endmodule

bind eased_frame_ramp_generator efr_checker u_efr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_frame_value (rsp_if.frame_value),
   .rsp_running     (rsp_if.running)
);
`default_nettype wire
